// ===== design/lirs_pkg.sv =====
// shared types and constants of the lirs replacement block
package lirs_pkg;

    localparam int NUM_PAGES = 4096;
    localparam int PAGE_W    = 12;
    localparam int LINK_W    = 13;
    localparam int CAP_W     = 13;
    localparam int HL_W      = 12;

    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [LINK_W-1:0] link_t;

    localparam link_t LINK_NIL = LINK_W'(NUM_PAGES);
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd1024;
    localparam logic [HL_W-1:0]  HL_RESET  = 12'd10;

    localparam int REG_CAPACITY  = 0;
    localparam int REG_HIR_LIMIT = 1;

    // per page record held in the state memory
    typedef struct packed {
        logic  res;
        logic  hir;
        logic  ins;
        link_t sp;
        link_t sn;
        link_t qp;
        link_t qn;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        res: 1'b0, hir: 1'b1, ins: 1'b0,
        sp: LINK_NIL, sn: LINK_NIL, qp: LINK_NIL, qn: LINK_NIL
    };

endpackage

// ===== design/lirs_channels.sv =====
// handshake channel interfaces for page references and replacement results
interface lirs_page_if;
    import lirs_pkg::*;
    logic  valid;
    logic  ready;
    page_t page;
    modport source (output valid, output page, input ready);
    modport sink (input valid, input page, output ready);
endinterface

interface lirs_result_if;
    import lirs_pkg::*;
    logic  valid;
    logic  ready;
    logic  hit;
    logic  evict_valid;
    page_t evicted_page;
    logic  now_lir;
    modport source (output valid, output hit, output evict_valid, output evicted_page,
                    output now_lir, input ready);
    modport sink (input valid, input hit, input evict_valid, input evicted_page,
                  input now_lir, output ready);
endinterface

// ===== design/lirs_page_replacement.sv =====
// lirs page replacement engine with its per page state memory
//
// One page reference goes in per transaction on req and one result comes
// out per transaction on rsp. All per page state (resident, hir and
// in-stack bits, recency stack links and resident-hir queue links) lives in
// one memory of 4096 records with separate read and write addresses and a
// registered read; a sequencer walks the linked lists there, each record
// access being a read followed by a modify/write. A repeat of the previous
// page is only reported; any other reference runs the full sequence, with a
// pruning walk up the stack where one is needed, and its result may wait for
// a free output register. References are handled one at a time, and a
// finished result sits in the output register while the next reference is
// taken. After reset a clearing pass writes the reset record to every page
// before the first reference is accepted; the user must write configuration
// only while no reference is in flight, and the block does not enforce this.
// Registers: capacity at byte address 0, hir_limit at byte address 4.
module lirs_page_replacement (
    input  logic        clk,
    input  logic        rst_n,
    lirs_page_if.sink   req,
    lirs_result_if.source rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lirs_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LOOK, ST_EV_RD, ST_EV, ST_QU_A, ST_QU_B,
        ST_SU_RD, ST_SU, ST_SU_FIX, ST_SU_FIX2, ST_PT, ST_PT2, ST_PR_RD, ST_PR,
        ST_QH, ST_DM_RD, ST_DM, ST_W_RD, ST_W_CHK, ST_FIN_RD, ST_FIN,
        ST_RMW_RD, ST_RMW_WR
    } state_t;

    // link edits (one link, or both stack links for a push) done by the read-modify-write sub-sequence
    typedef enum logic [2:0] {
        E_QN, E_QP, E_SN, E_SP, E_PUSHS
    } edit_t;

    function automatic entry_t apply_edit(entry_t e, edit_t k, link_t v);
        entry_t r;
        r = e;
        case (k)
            E_QN:    r.qn = v;
            E_QP:    r.qp = v;
            E_SN:    r.sn = v;
            E_SP:    r.sp = v;
            E_PUSHS:
            begin
                r.sp = LINK_NIL;
                r.sn = v;
            end
            default: r = e;
        endcase
        return r;
    endfunction

    // state memory
    entry_t mem [NUM_PAGES];
    entry_t rdata_reg;
    logic   mem_we, mem_re;
    page_t  mem_waddr, mem_raddr;
    entry_t mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // control and list head registers
    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    state_t           cont_reg, cont_next;
    state_t           w_ret_reg, w_ret_next;
    page_t            clr_reg, clr_next;
    page_t            p_reg, p_next;
    page_t            prev_page_reg, prev_page_next;
    logic             prev_valid_reg, prev_valid_next;
    link_t            top_reg, top_next;
    link_t            bottom_reg, bottom_next;
    link_t            qhead_reg, qhead_next;
    link_t            qtail_reg, qtail_next;
    logic [CAP_W-1:0] free_reg, free_next;
    logic [CAP_W-1:0] lir_reg, lir_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [HL_W-1:0]  hl_reg, hl_next;
    logic             hit_reg, hit_next;
    logic             ev_valid_reg, ev_valid_next;
    page_t            ev_page_reg, ev_page_next;
    link_t            u_x_reg, u_x_next;
    link_t            u_pv_reg, u_pv_next;
    link_t            u_nx_reg, u_nx_next;
    link_t            s_pv_reg, s_pv_next;
    link_t            s_nx_reg, s_nx_next;
    link_t            qx_reg, qx_next;
    link_t            w_b_reg, w_b_next;
    link_t            w_fb_reg, w_fb_next;
    logic [LINK_W-1:0] w_n_reg, w_n_next;
    link_t            op_addr_reg, op_addr_next;
    edit_t            op_kind_reg, op_kind_next;
    link_t            op_val_reg, op_val_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_hit_reg, out_hit_next;
    logic             out_ev_reg, out_ev_next;
    page_t            out_page_reg, out_page_next;
    logic             out_lir_reg, out_lir_next;

    logic             accept;
    logic             out_free;
    logic             cfg_wr;
    link_t            p_link;
    entry_t           e;
    entry_t           w;
    logic [CAP_W-1:0] used;
    logic [CAP_W-1:0] new_cap;
    logic [CAP_W:0]   lir_sum;

    assign accept   = req.valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign p_link   = {1'b0, p_reg};
    assign e        = rdata_reg;

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.hit          = out_hit_reg;
    assign rsp.evict_valid  = out_ev_reg;
    assign rsp.evicted_page = out_page_reg;
    assign rsp.now_lir      = out_lir_reg;
    assign pready           = 1'b1;
    assign prdata = paddr[2] ? {{(32-HL_W){1'b0}}, hl_reg} : {{(32-CAP_W){1'b0}}, cap_reg};

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        cont_next       = cont_reg;
        w_ret_next      = w_ret_reg;
        clr_next        = clr_reg;
        p_next          = p_reg;
        prev_page_next  = prev_page_reg;
        prev_valid_next = prev_valid_reg;
        top_next        = top_reg;
        bottom_next     = bottom_reg;
        qhead_next      = qhead_reg;
        qtail_next      = qtail_reg;
        free_next       = free_reg;
        lir_next        = lir_reg;
        cap_next        = cap_reg;
        hl_next         = hl_reg;
        hit_next        = hit_reg;
        ev_valid_next   = ev_valid_reg;
        ev_page_next    = ev_page_reg;
        u_x_next        = u_x_reg;
        u_pv_next       = u_pv_reg;
        u_nx_next       = u_nx_reg;
        s_pv_next       = s_pv_reg;
        s_nx_next       = s_nx_reg;
        qx_next         = qx_reg;
        w_b_next        = w_b_reg;
        w_fb_next       = w_fb_reg;
        w_n_next        = w_n_reg;
        op_addr_next    = op_addr_reg;
        op_kind_next    = op_kind_reg;
        op_val_next     = op_val_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_hit_next    = out_hit_reg;
        out_ev_next     = out_ev_reg;
        out_page_next   = out_page_reg;
        out_lir_next    = out_lir_reg;
        mem_we          = 1'b0;
        mem_waddr       = p_reg;
        mem_wdata       = e;
        mem_re          = 1'b0;
        mem_raddr       = p_reg;
        w               = e;
        used            = '0;
        new_cap         = '0;
        lir_sum         = ({1'b0, lir_reg} + 14'd1) + {2'b00, hl_reg};

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = ENTRY_RESET;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == page_t'(NUM_PAGES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    p_next     = req.page;
                    mem_re     = 1'b1;
                    mem_raddr  = req.page;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (prev_valid_reg && prev_page_reg == p_reg)
                begin
                    // repeated page: report only
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_hit_next   = e.res;
                        out_ev_next    = 1'b0;
                        out_page_next  = '0;
                        out_lir_next   = !e.hir;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    hit_next        = e.res;
                    ev_valid_next   = 1'b0;
                    ev_page_next    = '0;
                    prev_page_next  = p_reg;
                    prev_valid_next = 1'b1;
                    state_next      = ST_SU_RD;
                    if (!e.res)
                    begin
                        if (free_reg == '0)
                        begin
                            if (qtail_reg != LINK_NIL)
                            begin
                                state_next = ST_EV_RD;
                            end
                        end
                        else
                        begin
                            free_next = free_reg - 1'b1;
                            if (free_reg > {1'b0, hl_reg})
                            begin
                                w.hir     = 1'b0;
                                mem_we    = 1'b1;
                                mem_wdata = w;
                                lir_next  = lir_reg + 1'b1;
                            end
                        end
                    end
                    else if (e.hir)
                    begin
                        // resident hir page leaves the queue
                        w.qp       = LINK_NIL;
                        w.qn       = LINK_NIL;
                        mem_we     = 1'b1;
                        mem_wdata  = w;
                        u_x_next   = p_link;
                        u_pv_next  = e.qp;
                        u_nx_next  = e.qn;
                        state_next = ST_QU_A;
                    end
                end
            end
            ST_EV_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = qtail_reg[PAGE_W-1:0];
                state_next = ST_EV;
            end
            ST_EV:
            begin
                // evict the queue tail; the free count stays unchanged
                w.res         = 1'b0;
                w.qp          = LINK_NIL;
                w.qn          = LINK_NIL;
                mem_we        = 1'b1;
                mem_waddr     = qtail_reg[PAGE_W-1:0];
                mem_wdata     = w;
                u_x_next      = qtail_reg;
                u_pv_next     = e.qp;
                u_nx_next     = e.qn;
                ev_valid_next = 1'b1;
                ev_page_next  = qtail_reg[PAGE_W-1:0];
                state_next    = ST_QU_A;
            end
            ST_QU_A:
            begin
                if (u_pv_reg == LINK_NIL)
                begin
                    if (qhead_reg == u_x_reg)
                    begin
                        qhead_next = u_nx_reg;
                    end
                    state_next = ST_QU_B;
                end
                else
                begin
                    op_addr_next = u_pv_reg;
                    op_kind_next = E_QN;
                    op_val_next  = u_nx_reg;
                    ret_next     = ST_QU_B;
                    state_next   = ST_RMW_RD;
                end
            end
            ST_QU_B:
            begin
                if (u_nx_reg == LINK_NIL)
                begin
                    if (qtail_reg == u_x_reg)
                    begin
                        qtail_next = u_pv_reg;
                    end
                    state_next = ST_SU_RD;
                end
                else
                begin
                    op_addr_next = u_nx_reg;
                    op_kind_next = E_QP;
                    op_val_next  = u_pv_reg;
                    ret_next     = ST_SU_RD;
                    state_next   = ST_RMW_RD;
                end
            end
            ST_SU_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_SU;
            end
            ST_SU:
            begin
                // take the page out of the recency stack
                if (e.sp == LINK_NIL && top_reg != p_link)
                begin
                    state_next = ST_PT;
                end
                else
                begin
                    s_pv_next = e.sp;
                    s_nx_next = e.sn;
                    w.sp      = LINK_NIL;
                    w.sn      = LINK_NIL;
                    mem_we    = 1'b1;
                    mem_wdata = w;
                    if (bottom_reg == p_link)
                    begin
                        w_b_next   = e.sp;
                        w_fb_next  = p_link;
                        w_n_next   = '0;
                        w_ret_next = ST_SU_FIX;
                        state_next = ST_W_RD;
                    end
                    else
                    begin
                        state_next = ST_SU_FIX;
                    end
                end
            end
            ST_SU_FIX:
            begin
                if (s_pv_reg == LINK_NIL)
                begin
                    top_next   = s_nx_reg;
                    state_next = ST_SU_FIX2;
                end
                else
                begin
                    op_addr_next = s_pv_reg;
                    op_kind_next = E_SN;
                    op_val_next  = s_nx_reg;
                    ret_next     = ST_SU_FIX2;
                    state_next   = ST_RMW_RD;
                end
            end
            ST_SU_FIX2:
            begin
                if (s_nx_reg != LINK_NIL)
                begin
                    op_addr_next = s_nx_reg;
                    op_kind_next = E_SP;
                    op_val_next  = s_pv_reg;
                    ret_next     = ST_PT;
                    state_next   = ST_RMW_RD;
                end
                else
                begin
                    state_next = ST_PT;
                end
            end
            ST_PT:
            begin
                op_addr_next = p_link;
                op_kind_next = E_PUSHS;
                op_val_next  = top_reg;
                ret_next     = ST_PT2;
                state_next   = ST_RMW_RD;
            end
            ST_PT2:
            begin
                top_next = p_link;
                if (top_reg == LINK_NIL)
                begin
                    bottom_next = p_link;
                    state_next  = ST_PR_RD;
                end
                else
                begin
                    op_addr_next = top_reg;
                    op_kind_next = E_SP;
                    op_val_next  = p_link;
                    ret_next     = ST_PR_RD;
                    state_next   = ST_RMW_RD;
                end
            end
            ST_PR_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_PR;
            end
            ST_PR:
            begin
                w.res  = 1'b1;
                mem_we = 1'b1;
                if (e.hir && e.ins)
                begin
                    // promotion to lir, then demote the bottom if over budget
                    w.hir    = 1'b0;
                    lir_next = lir_reg + 1'b1;
                    if (lir_sum > {1'b0, cap_reg})
                    begin
                        state_next = ST_DM_RD;
                    end
                    else
                    begin
                        state_next = ST_FIN_RD;
                    end
                end
                else if (e.hir)
                begin
                    w.qp       = LINK_NIL;
                    w.qn       = qhead_reg;
                    qx_next    = p_link;
                    cont_next  = ST_FIN_RD;
                    state_next = ST_QH;
                end
                else
                begin
                    state_next = ST_FIN_RD;
                end
                mem_wdata = w;
            end
            ST_QH:
            begin
                // finish a push at the queue head
                qhead_next = qx_reg;
                if (qhead_reg == LINK_NIL)
                begin
                    qtail_next = qx_reg;
                    state_next = cont_reg;
                end
                else
                begin
                    op_addr_next = qhead_reg;
                    op_kind_next = E_QP;
                    op_val_next  = qx_reg;
                    ret_next     = cont_reg;
                    state_next   = ST_RMW_RD;
                end
            end
            ST_DM_RD:
            begin
                if (bottom_reg == LINK_NIL)
                begin
                    state_next = ST_FIN_RD;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = bottom_reg[PAGE_W-1:0];
                    state_next = ST_DM;
                end
            end
            ST_DM:
            begin
                if (!e.hir)
                begin
                    w.qp       = LINK_NIL;
                    w.qn       = qhead_reg;
                    w.hir      = 1'b1;
                    w.ins      = 1'b0;
                    mem_we     = 1'b1;
                    mem_waddr  = bottom_reg[PAGE_W-1:0];
                    mem_wdata  = w;
                    lir_next   = lir_reg - 1'b1;
                    qx_next    = bottom_reg;
                    cont_next  = ST_W_RD;
                    w_b_next   = bottom_reg;
                    w_fb_next  = p_link;
                    w_n_next   = '0;
                    w_ret_next = ST_FIN_RD;
                    state_next = ST_QH;
                end
                else
                begin
                    state_next = ST_FIN_RD;
                end
            end
            ST_W_RD:
            begin
                // pruning walk toward the top
                if (w_b_reg == LINK_NIL)
                begin
                    bottom_next = w_fb_reg;
                    state_next  = w_ret_reg;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = w_b_reg[PAGE_W-1:0];
                    state_next = ST_W_CHK;
                end
            end
            ST_W_CHK:
            begin
                if (e.hir && w_n_reg < LINK_W'(NUM_PAGES))
                begin
                    w.ins      = 1'b0;
                    mem_we     = 1'b1;
                    mem_waddr  = w_b_reg[PAGE_W-1:0];
                    mem_wdata  = w;
                    w_b_next   = e.sp;
                    w_n_next   = w_n_reg + 1'b1;
                    state_next = ST_W_RD;
                end
                else
                begin
                    bottom_next = e.hir ? w_fb_reg : w_b_reg;
                    state_next  = w_ret_reg;
                end
            end
            ST_FIN_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    w.ins          = 1'b1;
                    mem_we         = 1'b1;
                    mem_wdata      = w;
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_ev_next    = ev_valid_reg;
                    out_page_next  = ev_page_reg;
                    out_lir_next   = !e.hir;
                    state_next     = ST_IDLE;
                end
            end
            ST_RMW_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = op_addr_reg[PAGE_W-1:0];
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = op_addr_reg[PAGE_W-1:0];
                mem_wdata  = apply_edit(e, op_kind_reg, op_val_reg);
                state_next = ret_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register writes: user must issue them only while no reference is in flight; not enforced
        if (cfg_wr)
        begin
            new_cap = pwdata[CAP_W-1:0];
            used    = (cap_reg >= free_reg) ? (cap_reg - free_reg) : '0;
            if (paddr[2] == 1'(REG_HIR_LIMIT))
            begin
                hl_next = pwdata[HL_W-1:0];
            end
            else if (paddr[2] == 1'(REG_CAPACITY))
            begin
                cap_next  = new_cap;
                free_next = (new_cap > used) ? (new_cap - used) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            ret_reg        <= ST_IDLE;
            cont_reg       <= ST_IDLE;
            w_ret_reg      <= ST_IDLE;
            clr_reg        <= '0;
            prev_page_reg  <= '0;
            prev_valid_reg <= 1'b0;
            top_reg        <= LINK_NIL;
            bottom_reg     <= LINK_NIL;
            qhead_reg      <= LINK_NIL;
            qtail_reg      <= LINK_NIL;
            free_reg       <= CAP_RESET;
            lir_reg        <= '0;
            cap_reg        <= CAP_RESET;
            hl_reg         <= HL_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            cont_reg       <= cont_next;
            w_ret_reg      <= w_ret_next;
            clr_reg        <= clr_next;
            prev_page_reg  <= prev_page_next;
            prev_valid_reg <= prev_valid_next;
            top_reg        <= top_next;
            bottom_reg     <= bottom_next;
            qhead_reg      <= qhead_next;
            qtail_reg      <= qtail_next;
            free_reg       <= free_next;
            lir_reg        <= lir_next;
            cap_reg        <= cap_next;
            hl_reg         <= hl_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        hit_reg      <= hit_next;
        ev_valid_reg <= ev_valid_next;
        ev_page_reg  <= ev_page_next;
        u_x_reg      <= u_x_next;
        u_pv_reg     <= u_pv_next;
        u_nx_reg     <= u_nx_next;
        s_pv_reg     <= s_pv_next;
        s_nx_reg     <= s_nx_next;
        qx_reg       <= qx_next;
        w_b_reg      <= w_b_next;
        w_fb_reg     <= w_fb_next;
        w_n_reg      <= w_n_next;
        op_addr_reg  <= op_addr_next;
        op_kind_reg  <= op_kind_next;
        op_val_reg   <= op_val_next;
        out_hit_reg  <= out_hit_next;
        out_ev_reg   <= out_ev_next;
        out_page_reg <= out_page_next;
        out_lir_reg  <= out_lir_next;
    end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the lirs page replacement block
module testbench;
    import lirs_pkg::*;

    localparam int NIL        = NUM_PAGES;
    localparam int SETTLE     = 200;        // cycles after the last result before a register write
    localparam int CYCLE_CAP  = 30_000_000; // covers the clearing pass and long pruning walks

    // one replacement outcome as seen on the result channel
    typedef struct {
        bit    hit;
        bit    evict_valid;
        page_t evicted_page;
        bit    now_lir;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lirs_page_if   req ();
    lirs_result_if rsp ();

    lirs_page_replacement u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor state: lirs stack and resident-hir queue in link arrays
    // ------------------------------------------------------------------
    bit cached[NUM_PAGES];
    bit is_hir[NUM_PAGES];
    bit stacked[NUM_PAGES];
    int stk_up[NUM_PAGES];    // toward the stack top
    int stk_down[NUM_PAGES];  // toward the stack bottom
    int q_up[NUM_PAGES];
    int q_down[NUM_PAGES];
    int top_pg, bottom_lir, q_head, q_tail;
    int cap_slots, hir_slots, slots_free, lir_total;
    int last_pg;
    bit last_seen;

    outcome_t expected_outcomes[$];
    page_t    pending_pages[$];

    // directed references: field extremes, repeats, misses, promotions
    int directed_pages[20] = '{0, 0, 4095, 4095, 0, 1, 2, 0, 2048, 1, 4095, 7, 7, 3, 0,
                               2048, 1365, 2730, 5, 5};

    int  mismatches = 0;
    int  refs_taken = 0;
    int  outcomes_seen = 0;
    int  evictions_seen = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;        // last stretch of the run: no new random idling on either side
    bit  req_taken = 1'b0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on outcome %0d: %s got %0d expected %0d",
                 outcomes_seen, what, got, want);
        mismatches++;
    endtask

    function automatic void model_clear();
        for (int i = 0; i < NUM_PAGES; i++)
        begin
            cached[i] = 0; is_hir[i] = 1; stacked[i] = 0;
            stk_up[i] = NIL; stk_down[i] = NIL; q_up[i] = NIL; q_down[i] = NIL;
        end
        top_pg = NIL; bottom_lir = NIL; q_head = NIL; q_tail = NIL;
        cap_slots = CAP_RESET; hir_slots = HL_RESET; slots_free = CAP_RESET;
        lir_total = 0; last_pg = 0; last_seen = 0;
    endfunction

    // capacity change keeps the pages in use and recomputes the free count
    function automatic void model_set_capacity(input int nc);
        int used;
        used = (cap_slots >= slots_free) ? cap_slots - slots_free : 0;
        slots_free = (nc > used) ? nc - used : 0;
        cap_slots = nc;
    endfunction

    function automatic void queue_drop(input int x);
        int a, b;
        a = q_up[x];
        b = q_down[x];
        if (a == NIL)
        begin
            if (q_head == x) q_head = b;
        end
        else
            q_down[a] = b;
        if (b == NIL)
        begin
            if (q_tail == x) q_tail = a;
        end
        else
            q_up[b] = a;
        q_up[x] = NIL;
        q_down[x] = NIL;
    endfunction

    function automatic void queue_add(input int x);
        q_up[x] = NIL;
        q_down[x] = q_head;
        if (q_head == NIL) q_tail = x;
        else q_up[q_head] = x;
        q_head = x;
    endfunction

    // walk upward dropping hir entries until an lir page marks the bottom
    function automatic void prune(input int start, input int fallback);
        int b, n;
        b = start;
        n = 0;
        while (b != NIL && is_hir[b] && n < NUM_PAGES)
        begin
            stacked[b] = 0;
            b = stk_up[b];
            n++;
        end
        if (b == NIL || is_hir[b]) b = fallback;
        bottom_lir = b;
    endfunction

    function automatic void stack_drop(input int p);
        int a, b;
        a = stk_up[p];
        b = stk_down[p];
        if (a == NIL && top_pg != p) return;
        if (p == bottom_lir) prune(a, p);
        if (a == NIL) top_pg = b;
        else stk_down[a] = b;
        if (b != NIL) stk_up[b] = a;
        stk_up[p] = NIL;
        stk_down[p] = NIL;
    endfunction

    function automatic void stack_add(input int p);
        stk_up[p] = NIL;
        stk_down[p] = top_pg;
        if (top_pg == NIL) bottom_lir = p;
        else stk_up[top_pg] = p;
        top_pg = p;
    endfunction

    function automatic outcome_t lirs_reference(input page_t pg);
        outcome_t o;
        int p, v, b;
        p = pg;
        o.hit = cached[p];
        o.evict_valid = 0;
        o.evicted_page = '0;
        if (!(last_seen && last_pg == p))
        begin
            last_pg = p;
            last_seen = 1;
            if (!cached[p])
            begin
                if (slots_free == 0)
                begin
                    // evict the oldest resident hir page, if any
                    if (q_tail != NIL)
                    begin
                        v = q_tail;
                        cached[v] = 0;
                        queue_drop(v);
                        o.evict_valid = 1;
                        o.evicted_page = page_t'(v);
                        slots_free++;
                    end
                end
                else if (slots_free > hir_slots)
                begin
                    is_hir[p] = 0;
                    lir_total++;
                end
                if (slots_free > 0) slots_free--;
            end
            else if (is_hir[p])
                queue_drop(p);

            stack_drop(p);
            stack_add(p);
            cached[p] = 1;

            if (is_hir[p] && stacked[p])
            begin
                // promotion; demote the bottom lir page if over budget
                is_hir[p] = 0;
                lir_total++;
                if (lir_total + hir_slots > cap_slots)
                begin
                    b = bottom_lir;
                    if (b != NIL && !is_hir[b])
                    begin
                        queue_add(b);
                        is_hir[b] = 1;
                        stacked[b] = 0;
                        lir_total--;
                        prune(b, p);
                    end
                end
            end
            else if (is_hir[p])
                queue_add(p);
            stacked[p] = 1;
        end
        o.now_lir = !is_hir[p];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // request driver: changes at the falling edge, bursts of idle cycles
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge clk)
    begin
        req_taken <= req.valid && req.ready;
        if (rst_n && req.valid && req.ready)
        begin
            expected_outcomes.insert(expected_outcomes.size(), lirs_reference(req.page));
            refs_taken++;
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.page  = '0;
    end

    always @(negedge clk)
    begin
        if (rst_n && !(req.valid && !req_taken))
        begin
            if (send_gap > 0)
            begin
                req.valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                req.valid <= 1'b0;
                send_gap  <= $urandom_range(1, 12);
            end
            else if (pending_pages.size() > 0)
            begin
                req.valid <= 1'b1;
                req.page  <= pending_pages.pop_front();
            end
            else
                req.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result side: random stalls plus one long hold-off so the block backs up
    // ------------------------------------------------------------------
    int  stall_left = 0;
    bit  long_hold_done = 1'b0;

    initial rsp.ready = 1'b0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && refs_taken >= 150)
            begin
                long_hold_done <= 1'b1;
                stall_left     <= 600;
                rsp.ready      <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp.ready  <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(0, 11);
                rsp.ready  <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // compare each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            outcome_t want;
            if (expected_outcomes.size() == 0)
            begin
                $display("unexpected result transaction %0d", outcomes_seen);
                mismatches++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (rsp.hit !== want.hit) report("hit", rsp.hit, want.hit);
                if (rsp.evict_valid !== want.evict_valid)
                    report("evict_valid", rsp.evict_valid, want.evict_valid);
                if (rsp.evicted_page !== want.evicted_page)
                    report("evicted_page", rsp.evicted_page, want.evicted_page);
                if (rsp.now_lir !== want.now_lir)
                    report("now_lir", rsp.now_lir, want.now_lir);
                if (want.evict_valid) evictions_seen++;
            end
            outcomes_seen++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequencing
    // ------------------------------------------------------------------
    task automatic drain();
        wait (pending_pages.size() == 0 && !req.valid && expected_outcomes.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // setup then access phase; register latches with psel, penable and pwrite high
    task automatic reg_write(input int idx, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_cache(input int cap, input int hl);
        drain();
        reg_write(REG_CAPACITY, cap);
        model_set_capacity(cap);
        reg_write(REG_HIR_LIMIT, hl);
        hir_slots = hl;
    endtask

    // mostly a hot working set, some repeats and cold pages, a few from the whole range
    task automatic queue_refs(input int n, input int hot, input int cold);
        int r;
        page_t pg;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 65) pg = page_t'($urandom_range(0, hot - 1));
            else if (r < 80 && pending_pages.size() > 0) pg = pending_pages[$];
            else if (r < 96) pg = page_t'($urandom_range(0, cold - 1));
            else pg = page_t'($urandom);
            pending_pages.insert(pending_pages.size(), pg);
        end
    endtask

    initial
    begin
        model_clear();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, repeats, misses, promotions under defaults
        foreach (directed_pages[k])
            pending_pages.insert(pending_pages.size(), page_t'(directed_pages[k]));

        // smallest cache: constant eviction, promotion and demotion
        set_cache(3, 2);
        queue_refs(300, 4, 8);

        // largest limits: capacity top bit and all hir_limit bits
        set_cache(4096, 4095);
        queue_refs(200, 16, 4096);

        // capacity not above hir_limit; demotion fires on every promotion
        set_cache(5, 10);
        queue_refs(200, 6, 12);

        set_cache(4095, 2);
        queue_refs(120, 32, 4096);

        set_cache(40, 4);
        queue_refs(400, 30, 80);

        set_cache(200, 2);
        queue_refs(400, 150, 400);

        // final stretch with no new random idling on either side
        set_cache(16, 3);
        wait (pending_pages.size() == 0 && !req.valid);
        quiet = 1'b1;
        queue_refs(300, 12, 30);

        wait (pending_pages.size() == 0 && !req.valid && expected_outcomes.size() == 0);
        repeat (SETTLE) @(posedge clk);
        $display("%0d references checked, %0d of them caused an eviction", outcomes_seen,
                 evictions_seen);
        $display("cache sizes 3 to 4096 with hir limits 2 to 4095, stalls and a long hold-off");
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lirs_pkg.sv
design/lirs_channels.sv
design/lirs_page_replacement.sv
tb/testbench.sv
